/* rtl/core/led_strip_pattern_generator_macros.svh */
// Assertion macros shared by the LED strip pattern generator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LED_STRIP_PATTERN_GENERATOR_MACROS_SVH
`define LED_STRIP_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lspg_pkg.sv */
// Package of the LED strip pattern generator: codes, types and the color wheel.
// No dependencies; used by lspg_div and led_strip_pattern_generator.
`timescale 1ns / 1ps
`default_nettype none

package lspg_pkg;

	// Mode register codes.
	localparam logic [2:0] MODE_OFF     = 3'd0;
	localparam logic [2:0] MODE_SOLID   = 3'd1;
	localparam logic [2:0] MODE_FLASH   = 3'd2;
	localparam logic [2:0] MODE_RAINBOW = 3'd3;
	localparam logic [2:0] MODE_CYCLE   = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_SOLID_COLOR = 2'd1;
	localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

	// Divider of the rainbow cycle spacing: 256 / n, one quotient bit a step.
	localparam logic [8:0] DIVIDEND  = 9'd256;
	localparam logic [3:0] DIV_STEPS = 4'd9;

	// Color wheel segment bounds.
	localparam logic [7:0] WHEEL_SEG1 = 8'd85;
	localparam logic [7:0] WHEEL_SEG2 = 8'd170;
	localparam logic [7:0] FULL       = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       done;
		logic [8:0] quot;
		logic [6:0] rem;
	} div_res_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic rgb_t wheel(input logic [7:0] pos);
		logic [7:0] q;
		logic [7:0] t3;
		rgb_t       c;
		q = FULL - pos;
		if (q < WHEEL_SEG1) begin
			t3 = 8'({1'b0, q} + {q, 1'b0});
			c.r = FULL - t3;
			c.g = '0;
			c.b = t3;
		end else if (q < WHEEL_SEG2) begin
			q = q - WHEEL_SEG1;
			t3 = 8'({1'b0, q} + {q, 1'b0});
			c.r = '0;
			c.g = t3;
			c.b = FULL - t3;
		end else begin
			q = q - WHEEL_SEG2;
			t3 = 8'({1'b0, q} + {q, 1'b0});
			c.r = t3;
			c.g = FULL - t3;
			c.b = '0;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/lspg_div.sv */
// Iterative restoring divider that computes 256 / n and its remainder.
// Depends on lspg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lspg_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [6:0]      divisor,
	output lspg_pkg::div_res_t   res
);
	import lspg_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [3:0] cnt_q;
	logic [8:0] dvd_q;
	logic [6:0] rem_q;
	logic [8:0] quot_q;
	logic [7:0] trial;
	logic [7:0] diff;
	logic       ge;

	// One partial remainder step per cycle.
	assign trial = {rem_q, dvd_q[8]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == DIV_STEPS - 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= DIVIDEND;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[7:0], 1'b0};
			rem_q  <= ge ? diff[6:0] : trial[6:0];
			quot_q <= {quot_q[7:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/led_strip_pattern_generator.sv */
// Top level of the LED strip pattern generator: registers, frame sequencer and output stage.
// Depends on lspg_pkg, lspg_div and led_strip_pattern_generator_macros.svh.
//
//   Channel   Signals                                        Direction
//   ------    ---------------------------------------------  ---------
//   in        in_valid, in_ready, restart                    sink
//   out       out_valid, out_ready, pixel_index, red, green,
//             blue, white, last_pixel                        source
//   cfg       cfg_we, cfg_index, cfg_data                    sink, write only
//
// A frame transaction, where n is the clamped pixel count, accepts the request, runs the
// divider that works out the rainbow cycle spacing 256 / n, starts emitting and then
// sends one pixel per cycle while out_ready is high.
// Pixels leave through a single output register; a stall on out_ready holds the sequencer
// on the current pixel. in_ready is high only while no frame is in progress.
// Reset clears the registers to mode off, black, 64 pixels and animation step zero.
`timescale 1ns / 1ps
`default_nettype none
`include "led_strip_pattern_generator_macros.svh"

module led_strip_pattern_generator #(
	parameter int MAX_PIXELS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [5:0]       pixel_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       white,
	output logic             last_pixel,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import lspg_pkg::*;

	localparam logic [6:0] MaxPix = 7'(MAX_PIXELS);

	// Configuration registers.
	logic [2:0]  mode_q;
	logic [31:0] solid_q;
	logic [6:0]  count_q;

	// Frame state.
	state_t      state_q;
	state_t      state_d;
	logic [7:0]  step_q;
	logic [5:0]  pix_q;
	logic [7:0]  pos_q;
	logic [6:0]  racc_q;

	// Output register.
	logic        out_valid_q;
	logic [5:0]  idx_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  white_q;
	logic        last_q;

	logic        in_acc;
	logic        load;
	logic        last_load;
	logic [6:0]  n_eff;
	logic [6:0]  n_m1;
	div_res_t    div_res;
	logic [7:0]  rsum;
	logic        rge;
	logic [7:0]  wpos;
	rgb_t        wcol;
	logic [31:0] color;

	// A pixel count of zero draws one pixel; counts above the maximum are clipped.
	always_comb begin
		if (count_q == 7'd0) begin
			n_eff = 7'd1;
		end else if (count_q > MaxPix) begin
			n_eff = MaxPix;
		end else begin
			n_eff = count_q;
		end
	end
	assign n_m1 = n_eff - 7'd1;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_OFF;
			solid_q <= '0;
			count_q <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        mode_q  <= cfg_data[2:0];
				REG_SOLID_COLOR: solid_q <= cfg_data;
				REG_PIXEL_COUNT: count_q <= cfg_data[6:0];
				default:         ;
			endcase
		end
	end

	lspg_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc),
		.divisor (n_eff),
		.res     (div_res)
	);

	// Sequencer: next state and the pixel load strobe.
	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		last_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				load      = !out_valid_q || out_ready;
				last_load = load && ({1'b0, pix_q} == n_m1);
				if (last_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The step is cleared on a restart frame and advances once each frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (in_acc && restart) begin
			step_q <= '0;
		end else if (last_load) begin
			step_q <= step_q + 8'd1;
		end
	end

	// Rainbow cycle position floor(i * 256 / n) tracked as quotient plus remainder:
	// each pixel adds 256 / n and carries one more when the remainder sum reaches n.
	assign rsum = {1'b0, racc_q} + {1'b0, div_res.rem};
	assign rge  = rsum >= {1'b0, n_eff};

	always_ff @(posedge clk) begin
		if (div_res.done) begin
			pix_q  <= '0;
			pos_q  <= '0;
			racc_q <= '0;
		end else if (load) begin
			pix_q  <= pix_q + 6'd1;
			pos_q  <= pos_q + div_res.quot[7:0] + {7'd0, rge};
			racc_q <= rge ? 7'(rsum - {1'b0, n_eff}) : rsum[6:0];
		end
	end

	// Color of the current pixel.
	always_comb begin
		if (mode_q == MODE_CYCLE) begin
			wpos = pos_q + step_q;
		end else begin
			wpos = 8'({2'b0, pix_q} + step_q);
		end
		wcol = wheel(wpos);
		case (mode_q)
			MODE_SOLID:   color = solid_q;
			MODE_FLASH:   color = step_q[0] ? 32'd0 : solid_q;
			MODE_RAINBOW: color = {wcol.r, wcol.g, wcol.b, 8'd0};
			MODE_CYCLE:   color = {wcol.r, wcol.g, wcol.b, 8'd0};
			default:      color = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q   <= pix_q;
			red_q   <= color[31:24];
			green_q <= color[23:16];
			blue_q  <= color[15:8];
			white_q <= color[7:0];
			last_q  <= last_load;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = idx_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign white       = white_q;
	assign last_pixel  = last_q;

	// The divider result must satisfy 256 = q * n + r with r below n.
	`LSPG_ASSERT_IMPL(a_div_exact, clk, arst_n, div_res.done, (({7'd0, div_res.quot} * {9'd0, n_eff} + {9'd0, div_res.rem}) == 16'd256) && (div_res.rem < n_eff), "divider result is wrong")
	// Loading the final pixel ends the frame.
	`LSPG_ASSERT_NEXT(a_last_idle, clk, arst_n, last_load, (state_q == ST_IDLE) && out_valid && last_pixel, "frame did not end on its last pixel")
	// A frame transaction starts from the cleared or the held step.
	`LSPG_ASSERT_NEXT(a_step_start, clk, arst_n, in_acc, step_q == ($past(restart) ? 8'd0 : $past(step_q)), "animation step wrong at frame start")

endmodule

`default_nettype wire

/* sim/led_strip_pattern_generator_tb.sv */
// Self-checking testbench for led_strip_pattern_generator: frame requests in, pixel colors out.
// Depends on lspg_pkg for mode and register codes and on the RTL of the block under test.
`timescale 1ns / 1ps

module led_strip_pattern_generator_tb;

	import lspg_pkg::*;

	// Strip length that the block is built for; counts above it are clamped.
	localparam int MAX_PIXELS = 64;

	// Modes without a pattern of their own; they must draw black frames.
	localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

	// The one register index that decodes to nothing.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int RESET_CYCLES     = 12;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES    = 4;
	localparam int TAIL_CYCLES      = 20;

	// The longest correct wait with no transaction is the long receiver hold-off
	// plus the divider startup of one frame, so this limit leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [5:0] pidx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
		logic       last_flag;
	} pixel_color_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  white;
	logic        last_pixel;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_MODE;
	logic [31:0] cfg_data = '0;

	// Shadow copy of the block's registers and animation step, at their reset values.
	logic [2:0]  mode_reg = MODE_OFF;
	logic [31:0] color_reg = '0;
	logic [6:0]  count_reg = 7'd64;
	logic [7:0]  anim_step = '0;

	// Pixel colors predicted for accepted frames, oldest first.
	pixel_color_t pending_pixels[$];

	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;

	// Handshake pacing. idle_en turns random bursts on both sides on and off;
	// rx_long_hold asks the receiver for one long hold-off.
	bit idle_en = 1'b0;
	bit rx_long_hold = 1'b0;
	int rx_stall_left = 0;

	led_strip_pattern_generator #(
		.MAX_PIXELS(MAX_PIXELS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_index(pixel_index),
		.red(red),
		.green(green),
		.blue(blue),
		.white(white),
		.last_pixel(last_pixel),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Color wheel: a position maps to one of three ramps between the primaries.
	// The position is mirrored first, so position 0 is pure red fading toward green.
	function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
		logic [7:0] q;
		logic [7:0] t;
		q = FULL - pos;
		if (q < WHEEL_SEG1) begin
			t = 8'(q * 3);
			return {FULL - t, 8'd0, t};
		end else if (q < WHEEL_SEG2) begin
			t = 8'((q - WHEEL_SEG1) * 3);
			return {8'd0, t, FULL - t};
		end else begin
			t = 8'((q - WHEEL_SEG2) * 3);
			return {t, FULL - t, 8'd0};
		end
	endfunction

	// Works out every pixel of one frame from the shadow registers and queues it.
	// The step is cleared first on a restart and advances once after the frame,
	// whatever the mode.
	task automatic render_frame(input logic restart_bit);
		int unsigned n;
		int unsigned pos;
		pixel_color_t px;
		if (restart_bit) begin
			anim_step = '0;
		end
		n = {25'd0, count_reg};
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_PIXELS) begin
			n = MAX_PIXELS;
		end
		for (int unsigned i = 0; i < n; i++) begin
			px = '0;
			px.pidx = 6'(i);
			px.last_flag = (i + 1 == n);
			case (mode_reg)
				MODE_SOLID: begin
					{px.red, px.green, px.blue, px.white} = color_reg;
				end
				MODE_FLASH: begin
					// Even steps show the color, odd steps a dark frame.
					if (!anim_step[0]) begin
						{px.red, px.green, px.blue, px.white} = color_reg;
					end
				end
				MODE_RAINBOW: begin
					pos = i + anim_step;
					{px.red, px.green, px.blue} = wheel_rgb(8'(pos));
				end
				MODE_CYCLE: begin
					// The whole wheel is spread over the strip, whatever its length.
					pos = (i * 256) / n + anim_step;
					{px.red, px.green, px.blue} = wheel_rgb(8'(pos));
				end
				default: begin
				end
			endcase
			pending_pixels.push_back(px);
		end
		anim_step = anim_step + 8'd1;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Everything is sampled at the rising edge, before the block's own registers
	// update, so register writes, frame transactions and pixel transactions are seen
	// exactly as the block sees them.
	always @(posedge clk) begin : scoreboard
		pixel_color_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: begin
						mode_reg = cfg_data[2:0];
					end
					REG_SOLID_COLOR: begin
						color_reg = cfg_data;
					end
					REG_PIXEL_COUNT: begin
						count_reg = cfg_data[6:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				render_frame(restart);
			end
			if (out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$error("pixel transaction with no frame pending: pixel_index %0d",
						pixel_index);
					error_count++;
				end else begin
					want = pending_pixels.pop_front();
					compare_field("pixel_index", 32'(want.pidx), 32'(pixel_index));
					compare_field("red", 32'(want.red), 32'(red));
					compare_field("green", 32'(want.green), 32'(green));
					compare_field("blue", 32'(want.blue), 32'(blue));
					compare_field("white", 32'(want.white), 32'(white));
					compare_field("last_pixel", 32'(want.last_flag), 32'(last_pixel));
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Receiver side. Each falling edge sets out_ready once: a long hold-off when one
	// is asked for, short random stalls while idling is on, otherwise ready.
	always @(negedge clk) begin
		if (rx_stall_left != 0) begin
			out_ready <= 1'b0;
			rx_stall_left--;
		end else if (rx_long_hold) begin
			rx_long_hold = 1'b0;
			rx_stall_left = LONG_HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			rx_stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Register writes happen only while no frame is in flight; the shadow copy is
	// updated by the scoreboard when it sees the write enable.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offers one frame request and returns at the edge where the transaction is
	// taken. in_valid is left high so that a following request goes out without a
	// gap; wait_frames_done lowers it.
	task automatic offer_frame(input logic restart_bit);
		int gap;
		@(negedge clk);
		gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= restart_bit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stops offering and waits until every predicted pixel has come out. Every
	// frame yields at least one pixel, so the block is idle once the queue is empty.
	task automatic wait_frames_done();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A restart_odds of zero never restarts; otherwise one frame in restart_odds does.
	task automatic run_frames(input int frames, input int restart_odds);
		for (int k = 0; k < frames; k++) begin
			offer_frame(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
		end
	endtask

	// Picks a new setting of all three registers, with random junk in the unused
	// upper bits of the mode and count writes. Counts are mostly short to keep frames quick.
	task automatic randomize_config();
		logic [31:0] word;
		int pick;
		wait_frames_done();
		word = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			word[2:0] = 3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
		end else begin
			word[2:0] = 3'($urandom_range(MODE_OFF, MODE_CYCLE));
		end
		write_reg(REG_MODE, word);
		write_reg(REG_SOLID_COLOR, $urandom);
		word = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			word[6:0] = 7'($urandom_range(1, 16));
		end else if (pick < 9) begin
			word[6:0] = 7'($urandom_range(17, MAX_PIXELS));
		end else if ($urandom_range(0, 1) == 1) begin
			word[6:0] = 7'd0;
		end else begin
			word[6:0] = 7'($urandom_range(MAX_PIXELS + 1, 127));
		end
		write_reg(REG_PIXEL_COUNT, word);
	endtask

	// Right after reset the block is off with a full strip: one dark 64-pixel frame.
	task automatic test_reset_defaults();
		offer_frame(1'b0);
		wait_frames_done();
	endtask

	// Solid color at both color extremes and at every kind of pixel count:
	// a single pixel, zero (drawn as one), the full strip and counts past it.
	task automatic test_solid_color();
		write_reg(REG_MODE, {29'h1FFF_FFFF, MODE_SOLID});
		write_reg(REG_SOLID_COLOR, 32'hFFFF_FFFF);
		write_reg(REG_PIXEL_COUNT, 32'd1);
		offer_frame(1'b1);
		wait_frames_done();
		write_reg(REG_SOLID_COLOR, 32'h0000_0000);
		write_reg(REG_PIXEL_COUNT, 32'd0);
		offer_frame(1'b0);
		wait_frames_done();
		write_reg(REG_SOLID_COLOR, 32'hA55A_C33C);
		write_reg(REG_PIXEL_COUNT, 32'd127);
		offer_frame(1'b0);
		wait_frames_done();
		write_reg(REG_PIXEL_COUNT, {25'h1FF_FFFF, 7'd65});
		offer_frame(1'b1);
		wait_frames_done();
		write_reg(REG_PIXEL_COUNT, {25'h1FF_FFFF, 7'd64});
		offer_frame(1'b0);
		wait_frames_done();
	endtask

	// Flash alternates lit and dark frames; a restart on an odd step brings it
	// back to a lit frame.
	task automatic test_flash();
		write_reg(REG_MODE, {29'd0, MODE_FLASH});
		write_reg(REG_SOLID_COLOR, $urandom);
		write_reg(REG_PIXEL_COUNT, 32'd5);
		offer_frame(1'b1);
		offer_frame(1'b0);
		offer_frame(1'b0);
		offer_frame(1'b1);
		wait_frames_done();
	endtask

	task automatic test_rainbow();
		write_reg(REG_MODE, {29'd0, MODE_RAINBOW});
		write_reg(REG_PIXEL_COUNT, MAX_PIXELS);
		offer_frame(1'b1);
		offer_frame(1'b0);
		wait_frames_done();
	endtask

	// Rainbow cycle spacing depends on the count, so try several, including one.
	task automatic test_rainbow_cycle();
		write_reg(REG_MODE, {29'd0, MODE_CYCLE});
		write_reg(REG_PIXEL_COUNT, MAX_PIXELS);
		offer_frame(1'b0);
		wait_frames_done();
		write_reg(REG_PIXEL_COUNT, 32'd3);
		offer_frame(1'b1);
		wait_frames_done();
		write_reg(REG_PIXEL_COUNT, 32'd1);
		offer_frame(1'b0);
		wait_frames_done();
		write_reg(REG_PIXEL_COUNT, 32'd7);
		offer_frame(1'b0);
		wait_frames_done();
	endtask

	// Modes with no pattern draw black. A write to the unused register index must
	// leave the solid color alone, and plain off mode is dark too.
	task automatic test_undefined_modes();
		write_reg(REG_PIXEL_COUNT, 32'd9);
		for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
			write_reg(REG_MODE, m);
			offer_frame(1'b0);
			wait_frames_done();
		end
		write_reg(REG_MODE, {29'd0, MODE_SOLID});
		write_reg(REG_SOLID_COLOR, 32'h1234_5678);
		write_reg(REG_UNUSED, $urandom);
		offer_frame(1'b0);
		wait_frames_done();
		write_reg(REG_MODE, {29'd0, MODE_OFF});
		offer_frame(1'b0);
		wait_frames_done();
	endtask

	// Long run without restarts so the step walks through all 256 values and
	// wraps, while the registers change every few dozen frames.
	task automatic test_step_wrap();
		idle_en = 1'b1;
		for (int p = 0; p < 9; p++) begin
			randomize_config();
			run_frames(30, 0);
		end
		wait_frames_done();
	endtask

	// Random settings with occasional restarts; each phase idles or not at random.
	task automatic test_random_mix();
		for (int p = 0; p < 5; p++) begin
			randomize_config();
			idle_en = 1'($urandom_range(0, 1));
			run_frames(26, 8);
		end
		wait_frames_done();
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the
	// block stalls on a frame and keeps in_ready low until the receiver lets go.
	task automatic test_output_backpressure();
		idle_en = 1'b0;
		write_reg(REG_MODE, {29'd0, MODE_RAINBOW});
		write_reg(REG_PIXEL_COUNT, 32'd16);
		rx_long_hold = 1'b1;
		run_frames(6, 3);
		wait_frames_done();
	endtask

	// The last part runs with both sides at full rate.
	task automatic test_no_idle_tail();
		idle_en = 1'b0;
		for (int p = 0; p < 2; p++) begin
			randomize_config();
			run_frames(10, 4);
		end
		wait_frames_done();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		idle_en = 1'b1;

		test_reset_defaults();
		test_solid_color();
		test_flash();
		test_rainbow();
		test_rainbow_cycle();
		test_undefined_modes();
		test_step_wrap();
		test_random_mix();
		test_output_backpressure();
		test_no_idle_tail();

		// Any stray pixel after the last frame is caught by the scoreboard here.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0 && pending_pixels.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lspg_pkg.sv
rtl/core/lspg_div.sv
rtl/core/led_strip_pattern_generator.sv
sim/led_strip_pattern_generator_tb.sv
